@@ hw/rtl/s256sh_pkg.sv @@
// shared types, round constants and initial hash values for the sha-256 stream hasher
package s256sh_pkg;

  // eight 32-bit working or hash words, index 0 is word a / H0
  typedef logic [7:0][31:0] s256sh_state_t;

  // control from the sequencer to the message schedule window
  typedef struct packed {
    logic       byte_en;
    logic [7:0] byte_val;
    logic       rnd_en;
  } s256sh_wctl_t;

  localparam logic [7:0][31:0] INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_MARK = 8'h80;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

@@ hw/rtl/s256sh_round.sv @@
// one sha-256 compression round, reused for all 64 rounds of a block
module s256sh_round (
  input  s256sh_pkg::s256sh_state_t v,
  input  logic [31:0]               k,
  input  logic [31:0]               w,
  output s256sh_pkg::s256sh_state_t v_next
);

  logic [31:0] big0, big1, choose, major, t1, t2;

  always_comb begin
    big1   = {v[4][5:0], v[4][31:6]} ^ {v[4][10:0], v[4][31:11]} ^ {v[4][24:0], v[4][31:25]};
    choose = (v[4] & v[5]) ^ (~v[4] & v[6]);
    t1     = v[7] + big1 + choose + k + w;
    big0   = {v[0][1:0], v[0][31:2]} ^ {v[0][12:0], v[0][31:13]} ^ {v[0][21:0], v[0][31:22]};
    major  = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2     = big0 + major;
    v_next[7] = v[6];
    v_next[6] = v[5];
    v_next[5] = v[4];
    v_next[4] = v[3] + t1;
    v_next[3] = v[2];
    v_next[2] = v[1];
    v_next[1] = v[0];
    v_next[0] = t1 + t2;
  end

endmodule

@@ hw/rtl/s256sh_sched.sv @@
// block buffer and message schedule: 16-word sliding window, byte fill and round expansion
module s256sh_sched (
  input  logic                     clk,
  input  s256sh_pkg::s256sh_wctl_t wctl,
  output logic [31:0]              w_cur
);

  logic [31:0] win [16];
  logic [31:0] s0, s1, w_new;

  always_comb begin
    s0    = {win[1][6:0], win[1][31:7]} ^ {win[1][17:0], win[1][31:18]} ^ (win[1] >> 3);
    s1    = {win[14][16:0], win[14][31:17]} ^ {win[14][18:0], win[14][31:19]}
          ^ (win[14] >> 10);
    w_new = win[0] + s0 + win[9] + s1;
  end

  assign w_cur = win[0];

  // bytes shift in big-endian at the tail; rounds slide the window by one word
  always_ff @(posedge clk) begin
    if (wctl.byte_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= {win[i][23:0], win[i+1][31:24]};
      end
      win[15] <= {win[15][23:0], wctl.byte_val};
    end else if (wctl.rnd_en) begin
      for (int i = 0; i < 15; i++) begin
        win[i] <= win[i+1];
      end
      win[15] <= w_new;
    end
  end

endmodule

@@ hw/rtl/sha256_stream_hasher_unit.sv @@
// top level of the sha-256 stream hasher: sequencer, hash state and digest output buffer
// input: one beat a cycle while idle; a beat that fills the block holds input through the rounds and the add
// end of message: padding bytes shifted in, then rounds and the add per padded block, then the digest load
// digest words leave at one beat a cycle while m_tready is high, once the previous digest has drained
// no new input is taken while a block is padded or compressed; one round unit serves all rounds
// reset: synchronous, active high; clears control, loads initial hash, buffer left as is
module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,   // end_of_message
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest zero
  output logic        m_tlast    // last_word
);

  localparam logic [2:0] ST_IDLE  = 3'd0;  // taking input beats
  localparam logic [2:0] ST_ROUND = 3'd1;  // 64 compression rounds
  localparam logic [2:0] ST_FIN   = 3'd2;  // fold working words into hash
  localparam logic [2:0] ST_PAD   = 3'd3;  // shifting padding and length bytes
  localparam logic [2:0] ST_DONE  = 3'd4;  // hand digest to output buffer

  logic [2:0]  state;
  logic [5:0]  fill;          // bytes in the block buffer
  logic [63:0] total;         // message bytes, wraps
  logic [63:0] lenq;          // bit length, shifted out top byte first
  logic        pad_mode;      // end of message seen
  logic        mark_pending;  // 0x80 not yet written
  logic        final_blk;     // current block carries the length
  logic [5:0]  rnd;

  s256sh_pkg::s256sh_state_t h, v, v_round;
  s256sh_pkg::s256sh_wctl_t  wctl;
  logic [31:0] w_cur;
  logic [7:0]  pad_byte;

  // digest output buffer
  logic [31:0] obuf [8];
  logic [3:0]  ocnt;
  logic [2:0]  oidx;

  logic s_fire, m_fire;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;
  assign m_tvalid = (ocnt != 4'd0);
  assign m_fire   = m_tvalid && m_tready;
  assign m_tdata  = {5'd0, oidx, obuf[0]};
  assign m_tlast  = (oidx == 3'd7);

  // mark first, then zeros, then the length in the last eight bytes of the final block
  always_comb begin
    if (mark_pending) begin
      pad_byte = s256sh_pkg::PAD_MARK;
    end else if (final_blk && fill >= 6'd56) begin
      pad_byte = lenq[63:56];
    end else begin
      pad_byte = 8'd0;
    end
  end

  always_comb begin
    wctl.byte_en  = (s_fire && s_tuser) || (state == ST_PAD);
    wctl.byte_val = (state == ST_PAD) ? pad_byte : s_tdata;
    wctl.rnd_en   = (state == ST_ROUND);
  end

  s256sh_sched u_sched (
    .clk   (clk),
    .wctl  (wctl),
    .w_cur (w_cur)
  );

  s256sh_round u_round (
    .v      (v),
    .k      (s256sh_pkg::round_k(rnd)),
    .w      (w_cur),
    .v_next (v_round)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      fill         <= 6'd0;
      total        <= 64'd0;
      pad_mode     <= 1'b0;
      mark_pending <= 1'b0;
      final_blk    <= 1'b0;
      rnd          <= 6'd0;
      h            <= s256sh_pkg::INIT_H;
      ocnt         <= 4'd0;
      oidx         <= 3'd0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_fire) begin
            if (s_tuser) begin
              fill  <= fill + 6'd1;
              total <= total + 64'd1;
            end
            if (s_tlast) begin
              pad_mode     <= 1'b1;
              mark_pending <= 1'b1;
            end
            if (s_tuser && fill == 6'd63) begin
              // block full: compress first, padding follows if the message ended
              v     <= h;
              rnd   <= 6'd0;
              state <= ST_ROUND;
            end else if (s_tlast) begin
              state <= ST_PAD;
            end
          end
        end
        ST_PAD: begin
          fill <= fill + 6'd1;
          if (mark_pending) begin
            mark_pending <= 1'b0;
            // no room for the length behind the mark: one more block
            final_blk    <= (fill <= 6'd55);
            lenq         <= {total[60:0], 3'b000};
          end else if (final_blk && fill >= 6'd56) begin
            lenq <= {lenq[55:0], 8'd0};
          end
          if (fill == 6'd63) begin
            v     <= h;
            rnd   <= 6'd0;
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          v   <= v_round;
          rnd <= rnd + 6'd1;
          if (rnd == 6'd63) begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          for (int i = 0; i < 8; i++) begin
            h[i] <= h[i] + v[i];
          end
          if (!pad_mode) begin
            state <= ST_IDLE;
          end else if (!mark_pending && final_blk) begin
            state <= ST_DONE;
          end else begin
            // mark still to write, or the length block still to come
            if (!mark_pending) begin
              final_blk <= 1'b1;
            end
            state <= ST_PAD;
          end
        end
        ST_DONE: begin
          // wait until the previous digest has drained
          if (ocnt == 4'd0) begin
            for (int i = 0; i < 8; i++) begin
              obuf[i] <= h[i];
            end
            ocnt      <= 4'd8;
            oidx      <= 3'd0;
            h         <= s256sh_pkg::INIT_H;
            total     <= 64'd0;
            pad_mode  <= 1'b0;
            final_blk <= 1'b0;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase

      if (m_fire) begin
        for (int i = 0; i < 7; i++) begin
          obuf[i] <= obuf[i+1];
        end
        ocnt <= ocnt - 4'd1;
        oidx <= oidx + 3'd1;
      end
    end
  end

`ifndef SYNTHESIS
  a_ocnt_range: assert property (@(posedge clk) disable iff (rst) ocnt <= 4'd8)
    else $error("digest buffer count out of range");
  a_round_aligned: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |-> (fill == 6'd0))
    else $error("compression started on a partial block");
  a_digest_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && ocnt == 4'd0) |=> (ocnt == 4'd8 && oidx == 3'd0))
    else $error("digest not loaded into output buffer");
  a_last_word: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast) |-> (ocnt == 4'd1))
    else $error("last digest word out of step with buffer count");
`endif

endmodule
